// ----- src/e2q_pkg.sv -----
// ============================================================================
// e2q_pkg: shared types and constants for the Euler-to-quaternion converter
// Request and result payload structs, fixed-point widths and the arctangent
// table used by every CORDIC lane.
// ============================================================================
package e2q_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int QUAT_BITS  = 16;

    localparam int CORDIC_W = 33;
    localparam int ANGLE_W  = 36;
    localparam int PAIR_W   = 35;
    localparam int Q60_W    = 64;
    localparam int ATAN_N   = 32;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032875;

    localparam logic [31:0] ATAN_TURN32 [ATAN_N] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
        logic signed [ANGLE_BITS-1:0] roll_angle;
    } angles_t;

    typedef struct packed {
        logic signed [QUAT_BITS-1:0] quat_x;
        logic signed [QUAT_BITS-1:0] quat_y;
        logic signed [QUAT_BITS-1:0] quat_z;
        logic signed [QUAT_BITS-1:0] quat_w;
    } quat_t;

endpackage

// ----- src/euler_to_quaternion.sv -----
// ============================================================================
// euler_to_quaternion: pitch, yaw and roll angles to a unit quaternion
// Three CORDIC lanes form half-angle sines and cosines; a merge stage builds
// the triple products, then the output stage rounds and saturates to Q1.14.
//
//   channel  direction  handshake                      payload
//   angles   in         angles_valid / angles_stall    angles_t
//   quat     out        quat_valid / quat_stall        quat_t
//
// One request per cycle while the output is not stalled.
// Latency is set by the CORDIC pipeline (one micro-rotation per stage) plus
// the pair, triple, sum and output registers.
// Reset clears the valid pipeline only; data registers are not reset.
// A stalled result freezes the whole pipeline; angles_stall follows it.
// ============================================================================
module euler_to_quaternion
    import e2q_pkg::*;
#(
    parameter int FRACTION_BITS = 14,
    parameter int CORDIC_STAGES = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    angles_valid,
    output logic    angles_stall,
    input  angles_t angles,
    output logic    quat_valid,
    input  logic    quat_stall,
    output quat_t   quat
);

    localparam int LAT   = CORDIC_STAGES + 3;
    localparam int SH    = 60 - FRACTION_BITS;
    localparam logic signed [Q60_W-1:0] LIM  = Q60_W'(1) <<< FRACTION_BITS;
    localparam logic signed [Q60_W-1:0] HALF = Q60_W'(1) <<< (SH - 1);

    function automatic logic signed [QUAT_BITS-1:0] finish(
        input logic signed [Q60_W-1:0] q
    );
        logic signed [Q60_W-1:0] v;
        v = (q + HALF) >>> SH;
        if (v > LIM)
            v = LIM;
        else if (v < -LIM)
            v = -LIM;
        return QUAT_BITS'(v);
    endfunction

    logic                       en;
    logic [LAT-1:0]             valid_pipe_reg;
    logic [LAT-1:0]             valid_pipe_next;
    logic                       out_valid_reg;
    quat_t                      quat_reg;
    logic signed [CORDIC_W-1:0] sp, cp, sy, cy, sr, cr;
    logic signed [Q60_W-1:0]    sum_x, sum_y, sum_z, sum_w;

    assign en           = !(out_valid_reg && quat_stall);
    assign angles_stall = !en;

    e2q_cordic_lane #(.STAGES(CORDIC_STAGES)) u_lane_pitch (
        .clk     (clk),
        .en      (en),
        .angle   (angles.pitch_angle),
        .sin_q30 (sp),
        .cos_q30 (cp)
    );

    e2q_cordic_lane #(.STAGES(CORDIC_STAGES)) u_lane_yaw (
        .clk     (clk),
        .en      (en),
        .angle   (angles.yaw_angle),
        .sin_q30 (sy),
        .cos_q30 (cy)
    );

    e2q_cordic_lane #(.STAGES(CORDIC_STAGES)) u_lane_roll (
        .clk     (clk),
        .en      (en),
        .angle   (angles.roll_angle),
        .sin_q30 (sr),
        .cos_q30 (cr)
    );

    e2q_merge u_merge (
        .clk   (clk),
        .en    (en),
        .sp    (sp),
        .cp    (cp),
        .sy    (sy),
        .cy    (cy),
        .sr    (sr),
        .cr    (cr),
        .sum_x (sum_x),
        .sum_y (sum_y),
        .sum_z (sum_z),
        .sum_w (sum_w)
    );

    assign valid_pipe_next = {valid_pipe_reg[LAT-2:0], angles_valid};

    // advance valids only when the output can move
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            valid_pipe_reg <= valid_pipe_next;
            out_valid_reg  <= valid_pipe_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat_reg.quat_x <= finish(sum_x);
            quat_reg.quat_y <= finish(sum_y);
            quat_reg.quat_z <= finish(sum_z);
            quat_reg.quat_w <= finish(sum_w);
        end
    end

    assign quat_valid = out_valid_reg;
    assign quat       = quat_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        angles_valid && !angles_stall |=> valid_pipe_reg[0])
        else $error("accepted request did not enter the pipeline");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |=> $stable(valid_pipe_reg))
        else $error("pipeline advanced under output stall");

    a_w_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid |-> (FRACTION_BITS > 14) ||
            ($signed(quat.quat_w) <= $signed(17'(LIM)) &&
             $signed(quat.quat_w) >= -$signed(17'(LIM))))
        else $error("quaternion w outside saturation bounds");

endmodule

// ----- src/e2q_cordic_lane.sv -----
// ============================================================================
// e2q_cordic_lane: pipelined rotation-mode CORDIC for one angle
// Halves a binary angle and returns sine and cosine of the half-angle in Q30,
// one micro-rotation per register stage.
// ============================================================================
module e2q_cordic_lane
    import e2q_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [ANGLE_BITS-1:0] angle,
    output logic signed [CORDIC_W-1:0]   sin_q30,
    output logic signed [CORDIC_W-1:0]   cos_q30
);

    logic signed [CORDIC_W-1:0] x_reg [STAGES];
    logic signed [CORDIC_W-1:0] y_reg [STAGES];
    logic signed [ANGLE_W-1:0]  z_reg [STAGES];
    logic signed [ANGLE_W-1:0]  z_init;

    assign z_init = ANGLE_W'(angle) <<< (32 - ANGLE_BITS);

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam int SH = (i < ATAN_N) ? i : ATAN_N - 1;
        localparam logic signed [ANGLE_W-1:0] DA =
            ANGLE_W'({ATAN_TURN32[SH], 1'b0});

        logic signed [CORDIC_W-1:0] x_in;
        logic signed [CORDIC_W-1:0] y_in;
        logic signed [ANGLE_W-1:0]  z_in;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;

        if (i == 0) begin : g_first
            assign x_in = CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = z_init;
        end
        else begin : g_next
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
        end

        assign dx = y_in >>> SH;
        assign dy = x_in >>> SH;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_in[ANGLE_W-1])
                begin
                    x_reg[i] <= x_in - dx;
                    y_reg[i] <= y_in + dy;
                    z_reg[i] <= z_in - DA;
                end
                else
                begin
                    x_reg[i] <= x_in + dx;
                    y_reg[i] <= y_in - dy;
                    z_reg[i] <= z_in + DA;
                end
            end
        end
    end

    assign sin_q30 = y_reg[STAGES-1];
    assign cos_q30 = x_reg[STAGES-1];

endmodule

// ----- src/e2q_merge.sv -----
// ============================================================================
// e2q_merge: combine the lane results into quaternion sums
// Three register stages: rounded pair products, exact Q60 triple products,
// then the four signed sums.
// ============================================================================
module e2q_merge
    import e2q_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [CORDIC_W-1:0] sp,
    input  logic signed [CORDIC_W-1:0] cp,
    input  logic signed [CORDIC_W-1:0] sy,
    input  logic signed [CORDIC_W-1:0] cy,
    input  logic signed [CORDIC_W-1:0] sr,
    input  logic signed [CORDIC_W-1:0] cr,
    output logic signed [Q60_W-1:0]    sum_x,
    output logic signed [Q60_W-1:0]    sum_y,
    output logic signed [Q60_W-1:0]    sum_z,
    output logic signed [Q60_W-1:0]    sum_w
);

    function automatic logic signed [PAIR_W-1:0] pair_round(
        input logic signed [CORDIC_W-1:0] a,
        input logic signed [CORDIC_W-1:0] b
    );
        logic signed [2*CORDIC_W-1:0] prod;
        prod = a * b;
        prod = prod + ((2*CORDIC_W)'(1) <<< 29);
        return PAIR_W'(prod >>> 30);
    endfunction

    function automatic logic signed [Q60_W-1:0] triple_mul(
        input logic signed [PAIR_W-1:0]   p,
        input logic signed [CORDIC_W-1:0] c
    );
        logic signed [PAIR_W+CORDIC_W-1:0] full;
        full = p * c;
        return $signed(full[Q60_W-1:0]);
    endfunction

    logic signed [PAIR_W-1:0]   srcp_reg, crsp_reg, crcp_reg, srsp_reg;
    logic signed [CORDIC_W-1:0] sy_reg, cy_reg;
    logic signed [Q60_W-1:0]    t_srcpcy_reg, t_crspsy_reg, t_crspcy_reg, t_srcpsy_reg;
    logic signed [Q60_W-1:0]    t_crcpsy_reg, t_srspcy_reg, t_crcpcy_reg, t_srspsy_reg;
    logic signed [Q60_W-1:0]    sum_x_reg, sum_y_reg, sum_z_reg, sum_w_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srcp_reg <= pair_round(sr, cp);
            crsp_reg <= pair_round(cr, sp);
            crcp_reg <= pair_round(cr, cp);
            srsp_reg <= pair_round(sr, sp);
            sy_reg   <= sy;
            cy_reg   <= cy;

            t_srcpcy_reg <= triple_mul(srcp_reg, cy_reg);
            t_crspsy_reg <= triple_mul(crsp_reg, sy_reg);
            t_crspcy_reg <= triple_mul(crsp_reg, cy_reg);
            t_srcpsy_reg <= triple_mul(srcp_reg, sy_reg);
            t_crcpsy_reg <= triple_mul(crcp_reg, sy_reg);
            t_srspcy_reg <= triple_mul(srsp_reg, cy_reg);
            t_crcpcy_reg <= triple_mul(crcp_reg, cy_reg);
            t_srspsy_reg <= triple_mul(srsp_reg, sy_reg);

            sum_x_reg <= t_srcpcy_reg - t_crspsy_reg;
            sum_y_reg <= t_crspcy_reg + t_srcpsy_reg;
            sum_z_reg <= t_crcpsy_reg - t_srspcy_reg;
            sum_w_reg <= t_crcpcy_reg + t_srspsy_reg;
        end
    end

    assign sum_x = sum_x_reg;
    assign sum_y = sum_y_reg;
    assign sum_z = sum_z_reg;
    assign sum_w = sum_w_reg;

endmodule

// ----- verif/euler_to_quaternion_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// euler_to_quaternion_test: self-checking testbench for the Euler converter
// Drives pitch, yaw and roll requests through the valid/stall handshake and
// predicts each quaternion with a bit-exact fixed-point CORDIC. Results are
// checked in order, field by field, with random idling on both sides, a long
// result hold-off that backs up the pipeline and a drain pause.
// ============================================================================
module euler_to_quaternion_test;
    import e2q_pkg::*;

    localparam int     FRACTION_BITS = 14;
    localparam int     STAGES        = 16;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     RANDOM_COUNT  = 340;
    localparam longint GAIN_Q30      = 652032875;
    localparam longint ARCTAN_Q32 [STAGES] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331,  21354465,  10679838,  5340245,
        2670163,   1335087,   667544,    333772,
        166886,    83443,     41722,     20861
    };

    class quat_scoreboard;
        quat_t expected_quats[$];
        int    failures;

        function new();
            failures = 0;
        endfunction

        function int pending();
            return expected_quats.size();
        endfunction

        function void half_angle_sincos(input logic signed [ANGLE_BITS-1:0] ang,
                                        output longint sin_q30, output longint cos_q30);
            longint z;
            longint x;
            longint y;
            longint dx;
            longint dy;
            int     i;
            z = longint'(ang) * (longint'(1) <<< (32 - ANGLE_BITS));
            x = GAIN_Q30;
            y = 0;
            for (i = 0; i < STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARCTAN_Q32[i] * 2;
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARCTAN_Q32[i] * 2;
                end
            end
            sin_q30 = y;
            cos_q30 = x;
        endfunction

        function longint triple_q60(longint a, longint b, longint c);
            longint ab;
            ab = (a * b + (longint'(1) <<< 29)) >>> 30;
            return ab * c;
        endfunction

        function logic signed [QUAT_BITS-1:0] round_saturate(longint q60);
            longint v;
            longint lim;
            lim = longint'(1) <<< FRACTION_BITS;
            v = (q60 + (longint'(1) <<< (59 - FRACTION_BITS))) >>> (60 - FRACTION_BITS);
            if (v > lim)
                v = lim;
            if (v < -lim)
                v = -lim;
            return v[QUAT_BITS-1:0];
        endfunction

        function void note_request(angles_t req);
            longint sp, cp, sy, cy, sr, cr;
            quat_t  q;
            half_angle_sincos(req.pitch_angle, sp, cp);
            half_angle_sincos(req.yaw_angle, sy, cy);
            half_angle_sincos(req.roll_angle, sr, cr);
            q.quat_x = round_saturate(triple_q60(sr, cp, cy) - triple_q60(cr, sp, sy));
            q.quat_y = round_saturate(triple_q60(cr, sp, cy) + triple_q60(sr, cp, sy));
            q.quat_z = round_saturate(triple_q60(cr, cp, sy) - triple_q60(sr, sp, cy));
            q.quat_w = round_saturate(triple_q60(cr, cp, cy) + triple_q60(sr, sp, sy));
            expected_quats.push_back(q);
        endfunction

        function void compare_field(string field, logic signed [QUAT_BITS-1:0] want,
                                    logic signed [QUAT_BITS-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
                failures++;
            end
        endfunction

        function void check_result(quat_t got);
            quat_t want;
            if (expected_quats.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                failures++;
                return;
            end
            want = expected_quats.pop_front();
            compare_field("quat_x", want.quat_x, got.quat_x);
            compare_field("quat_y", want.quat_y, got.quat_y);
            compare_field("quat_z", want.quat_z, got.quat_z);
            compare_field("quat_w", want.quat_w, got.quat_w);
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    angles_valid;
    logic    angles_stall;
    angles_t angles;
    logic    quat_valid;
    logic    quat_stall;
    quat_t   quat;

    quat_scoreboard board = new();
    int             cycle_count = 0;
    int             hold_len = 0;
    bit             steady = 1'b0;

    euler_to_quaternion DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .angles_valid (angles_valid),
        .angles_stall (angles_stall),
        .angles       (angles),
        .quat_valid   (quat_valid),
        .quat_stall   (quat_stall),
        .quat         (quat)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("euler_to_quaternion test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && angles_valid && !angles_stall)
            board.note_request(angles);
        if (rst_n && quat_valid && !quat_stall)
            board.check_result(quat);
    end

    initial
    begin : result_sink
        int n;
        quat_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                n = hold_len;
                hold_len = 0;
                quat_stall <= 1'b1;
                repeat (n) @(posedge clk);
                quat_stall <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 3) == 0)
            begin
                quat_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                quat_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [ANGLE_BITS-1:0] random_angle();
        logic signed [ANGLE_BITS-1:0] corners [8] = '{
            -16'sd32768, -16'sd32767, -16'sd16384, -16'sd1,
            16'sd0, 16'sd1, 16'sd16384, 16'sd32767
        };
        if ($urandom_range(0, 9) < 7)
            return ANGLE_BITS'($urandom());
        return corners[3'($urandom_range(0, 7))];
    endfunction

    task automatic send_request(input angles_t req, input bit allow_gap);
        angles <= req;
        angles_valid <= 1'b1;
        @(posedge clk);
        while (angles_stall)
            @(posedge clk);
        if (allow_gap && !steady && $urandom_range(0, 3) == 0)
        begin
            angles_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        angles_t                      req;
        logic signed [ANGLE_BITS-1:0] directed [18][3] = '{
            '{16'sd0, 16'sd0, 16'sd0},
            '{-16'sd32768, -16'sd32768, -16'sd32768},
            '{16'sd32767, 16'sd32767, 16'sd32767},
            '{16'sd16384, 16'sd16384, 16'sd16384},
            '{-16'sd16384, -16'sd16384, -16'sd16384},
            '{-16'sd32768, 16'sd0, 16'sd0},
            '{16'sd0, -16'sd32768, 16'sd0},
            '{16'sd0, 16'sd0, -16'sd32768},
            '{16'sd32767, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd32767, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd32767},
            '{16'sd32767, -16'sd32768, 16'sd32767},
            '{-16'sd32768, 16'sd32767, -16'sd32768},
            '{16'sd1, -16'sd1, 16'sd1},
            '{16'sd8192, -16'sd8192, 16'sd24576},
            '{-16'sd32768, -16'sd32768, 16'sd0},
            '{16'sd16384, -16'sd32768, 16'sd16384},
            '{-16'sd21846, 16'sd10923, -16'sd5461}
        };
        int k;

        rst_n <= 1'b0;
        angles_valid <= 1'b0;
        angles <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < 18; k++)
        begin
            req.pitch_angle = directed[k][0];
            req.yaw_angle   = directed[k][1];
            req.roll_angle  = directed[k][2];
            send_request(req, 1'b1);
        end

        // hold off the sender until the pipeline empties
        angles_valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        // back up the pipeline behind a long result stall
        hold_len = 80;
        for (k = 0; k < 40; k++)
        begin
            req.pitch_angle = random_angle();
            req.yaw_angle   = random_angle();
            req.roll_angle  = random_angle();
            send_request(req, 1'b0);
        end

        for (k = 0; k < RANDOM_COUNT; k++)
        begin
            steady = (k >= RANDOM_COUNT - 60);
            req.pitch_angle = random_angle();
            req.yaw_angle   = random_angle();
            req.roll_angle  = random_angle();
            send_request(req, 1'b1);
        end

        angles_valid <= 1'b0;
        wait_drained();
        repeat (STAGES + 20) @(posedge clk);

        if (board.failures == 0)
            $display("euler_to_quaternion test passed");
        else
            $display("euler_to_quaternion test failed");
        $finish;
    end
endmodule
